FILE: design/multilevel_feedback_scheduler_unit_macros.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MFS_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define MFS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/mfs_pkg.sv
package mfs_pkg;

    // defaults for the top-level parameters
    localparam int SLOTS_DEF      = 64;
    localparam int ID_BITS_DEF    = 8;
    localparam int BURST_BITS_DEF = 16;

    // fixed field widths
    localparam int PRI_W   = 8;
    localparam int AGE_W   = 11;
    localparam int STAMP_W = 16;
    localparam int REM_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int QUO_W   = 12;

    typedef logic [1:0] t_code;

    // operations
    localparam t_code OP_INSERT = 2'd0;
    localparam t_code OP_PICK   = 2'd1;
    localparam t_code OP_AGE    = 2'd2;

    // result kinds
    localparam t_code KIND_ACK   = 2'd0;
    localparam t_code KIND_NEW   = 2'd1;
    localparam t_code KIND_KEEP  = 2'd2;
    localparam t_code KIND_EMPTY = 2'd3;

    // error codes
    localparam t_code ERR_NONE = 2'd0;
    localparam t_code ERR_PRI  = 2'd1;
    localparam t_code ERR_FULL = 2'd2;

    // queue levels
    localparam t_code LEV_1 = 2'd0;
    localparam t_code LEV_2 = 2'd1;
    localparam t_code LEV_3 = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_INC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_THR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_STEP = 3'd5;

    // register reset values
    localparam logic [PRI_W-1:0] BOUND_LOW_RST  = 8'd50;
    localparam logic [PRI_W-1:0] BOUND_MID_RST  = 8'd100;
    localparam logic [PRI_W-1:0] BOUND_HIGH_RST = 8'd150;
    localparam logic [AGE_W-1:0] AGE_INC_RST    = 11'd100;
    localparam logic [AGE_W-1:0] AGE_THR_RST    = 11'd1500;
    localparam logic [PRI_W-1:0] AGE_STEP_RST   = 8'd10;

endpackage

FILE: design/mfs_ifs.sv
interface mfs_req_if #(
    parameter int ID_BITS    = 8,
    parameter int BURST_BITS = 16
);
    import mfs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             operation;
    logic [ID_BITS-1:0]     thread_id;
    logic [PRI_W-1:0]       thread_priority;
    logic [BURST_BITS-1:0]  burst_estimate;
    logic                   current_running;
    logic [PRI_W-1:0]       current_priority;
    logic signed [REM_W-1:0] current_remaining;
    logic                   timer_flag;

    modport source (output valid, operation, thread_id, thread_priority, burst_estimate,
                    current_running, current_priority, current_remaining, timer_flag,
                    input ready);
    modport sink (input valid, operation, thread_id, thread_priority, burst_estimate,
                  current_running, current_priority, current_remaining, timer_flag,
                  output ready);
endinterface

interface mfs_rsp_if #(
    parameter int ID_BITS = 8
);
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [ID_BITS-1:0] chosen_id;
    logic [1:0]         error_code;

    modport source (output valid, result_kind, chosen_id, error_code, input ready);
    modport sink (input valid, result_kind, chosen_id, error_code, output ready);
endinterface

interface mfs_cfg_if;
    import mfs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/mfs_div.sv
module mfs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mfs_pkg::QUO_W-1:0]    i_dividend,
    input  logic [mfs_pkg::AGE_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [mfs_pkg::QUO_W-1:0]    o_quot,
    output logic [mfs_pkg::AGE_W-1:0]    o_rem
);
    import mfs_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0] r_quo;
    logic [AGE_W-1:0] r_rem;
    logic [AGE_W-1:0] r_dsr;
    logic [AGE_W:0]   trial;
    logic             fits;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? AGE_W'(trial - {1'b0, r_dsr}) : AGE_W'(trial);
                r_quo <= {r_quo[QUO_W-2:0], fits};
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: design/multilevel_feedback_scheduler_unit.sv
// Three-level feedback scheduler. Requests arrive on i_req (insert, pick, age),
// one response per request leaves on o_rsp; i_cfg writes the six registers
// (bounds and aging controls) and is always ready, to be used while idle.
// The ready table lives in a SLOTS-entry memory swept one slot per cycle by a
// single key comparator; each request runs through these steps:
//   insert : straight to the response when the priority is rejected, else a
//            first-free search, one slot per cycle, then the table write
//   pick   : one sweep per level looked at, L1 first, then L2 and L3
//   age    : one full sweep per waiting L2/L3 thread; a thread whose aging
//            reaches the threshold also goes through the 12-step divider,
//            multiply and saturating add.
// i_req.ready is high only while the sequencer is idle, one request at a time.
// A finished response sits in the output register; the next request is taken
// even while it waits, and the following response holds until o_rsp drains.
// Reset (synchronous, active low) empties the table, zeroes the arrival stamp
// and loads the default register values; no clearing pass is needed.
module multilevel_feedback_scheduler_unit #(
    parameter int SLOTS      = mfs_pkg::SLOTS_DEF,
    parameter int ID_BITS    = mfs_pkg::ID_BITS_DEF,
    parameter int BURST_BITS = mfs_pkg::BURST_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mfs_req_if.sink      i_req,
    mfs_rsp_if.source    o_rsp,
    mfs_cfg_if.sink      i_cfg
);
    import mfs_pkg::*;

    `include "multilevel_feedback_scheduler_unit_macros.svh"

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);
    localparam int CMP_W = (BURST_BITS > 16) ? BURST_BITS : 16;
    localparam int PROD_W = PRI_W + QUO_W;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [PRI_W-1:0]      pri;
        logic [BURST_BITS-1:0] burst;
        logic [AGE_W-1:0]      aging;
        logic [1:0]            lev;
        logic [STAMP_W-1:0]    stamp;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE, S_FREE, S_SCAN, S_DECIDE, S_AGE, S_DIV, S_MUL, S_ADD,
        S_PROMO, S_WRITE, S_DONE
    } t_state;

    // table storage
    t_slot r_mem [SLOTS];
    t_slot r_rdata;
    t_slot wr_word;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_done;      // already aged in the current pass

    // configuration
    logic [PRI_W-1:0] r_bound_low, r_bound_mid, r_bound_high, r_age_step;
    logic [AGE_W-1:0] r_age_inc, r_age_thr;

    // sequencer
    t_state             r_state;
    logic [STAMP_W-1:0] r_stamp;
    logic [IDX_W-1:0]   r_idx;
    logic               r_iss;
    logic               r_rd_v;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [1:0]         r_lev;

    // latched request
    logic [1:0]             r_op;
    logic                   r_run;
    logic [PRI_W-1:0]       r_cpri;
    logic [REM_W-1:0]       r_crem;
    logic                   r_timer;
    logic [ID_BITS-1:0]     r_tid;
    logic [PRI_W-1:0]       r_tpri;
    logic [BURST_BITS-1:0]  r_tburst;

    // current best slot; also the staging word for table writes
    logic             r_best_v;
    logic [IDX_W-1:0] r_best_idx;
    t_slot            r_best;

    logic [PROD_W-1:0] r_prod;
    logic [QUO_W-1:0]  r_quot;

    // pending result and output register
    logic [1:0]         r_res_kind, r_res_err;
    logic [ID_BITS-1:0] r_res_id;
    logic               r_o_valid;
    logic [1:0]         r_o_kind, r_o_err;
    logic [ID_BITS-1:0] r_o_id;

    // key compare of the slot read this cycle against the best so far
    logic [STAMP_W-1:0] cand_wait, best_wait;
    logic cand_ok, cand_ahead, cand_take, scan_last;
    assign cand_wait = r_stamp - r_rdata.stamp;
    assign best_wait = r_stamp - r_best.stamp;
    assign cand_ok = r_rd_v && r_valid[r_rd_idx] && (r_rdata.lev == r_lev)
                     && !((r_op == OP_AGE) && r_done[r_rd_idx]);
    always_comb begin
        if ((r_lev == LEV_1) && (r_rdata.burst != r_best.burst)) begin
            cand_ahead = r_rdata.burst < r_best.burst;
        end else if ((r_lev == LEV_2) && (r_rdata.pri != r_best.pri)) begin
            cand_ahead = r_rdata.pri > r_best.pri;
        end else begin
            cand_ahead = cand_wait > best_wait;
        end
    end
    assign cand_take = cand_ok && (!r_best_v || cand_ahead);
    assign scan_last = r_rd_v && (r_rd_idx == LAST);

    // aging arithmetic
    logic [QUO_W-1:0] ag_sum;
    logic [AGE_W-1:0] thr;
    logic             div_start, div_done;
    logic [QUO_W-1:0] div_quot;
    logic [AGE_W-1:0] div_rem;
    logic [PROD_W:0]  pri_sum;
    logic             rem_gt;
    assign ag_sum    = {1'b0, r_best.aging} + {1'b0, r_age_inc};
    assign thr       = (r_age_thr == '0) ? AGE_W'(1) : r_age_thr;
    assign div_start = (r_state == S_AGE) && (ag_sum >= {1'b0, thr});
    assign pri_sum   = {1'b0, r_prod} + (PROD_W + 1)'(r_best.pri);
    // running thread's remaining burst exceeds the burst of the L1 front
    assign rem_gt = !r_crem[REM_W-1]
                    && ((CMP_W + 1)'(r_crem[REM_W-2:0]) > (CMP_W + 1)'(r_best.burst));

    mfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ag_sum),
        .i_divisor  (thr),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // written word takes the live arrival stamp
    always_comb begin
        wr_word       = r_best;
        wr_word.stamp = r_stamp;
    end

    // table memory: one read port feeding the sweep, one write port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_idx];
        if (r_state == S_WRITE) begin
            r_mem[r_best_idx] <= wr_word;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.result_kind = r_o_kind;
    assign o_rsp.chosen_id   = r_o_id;
    assign o_rsp.error_code  = r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_done       <= '0;
            r_stamp      <= '0;
            r_iss        <= 1'b0;
            r_rd_v       <= 1'b0;
            r_best_v     <= 1'b0;
            r_o_valid    <= 1'b0;
            r_bound_low  <= BOUND_LOW_RST;
            r_bound_mid  <= BOUND_MID_RST;
            r_bound_high <= BOUND_HIGH_RST;
            r_age_inc    <= AGE_INC_RST;
            r_age_thr    <= AGE_THR_RST;
            r_age_step   <= AGE_STEP_RST;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_BOUND_LOW:  r_bound_low  <= i_cfg.data[PRI_W-1:0];
                    REG_BOUND_MID:  r_bound_mid  <= i_cfg.data[PRI_W-1:0];
                    REG_BOUND_HIGH: r_bound_high <= i_cfg.data[PRI_W-1:0];
                    REG_AGE_INC:    r_age_inc    <= i_cfg.data;
                    REG_AGE_THR:    r_age_thr    <= i_cfg.data;
                    REG_AGE_STEP:   r_age_step   <= i_cfg.data[PRI_W-1:0];
                    default: ;
                endcase
            end

            // S_DONE reloads the output register itself
            if (r_o_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op       <= i_req.operation;
                        r_run      <= i_req.current_running;
                        r_cpri     <= i_req.current_priority;
                        r_crem     <= i_req.current_remaining;
                        r_timer    <= i_req.timer_flag;
                        r_tid      <= i_req.thread_id;
                        r_tpri     <= i_req.thread_priority;
                        r_tburst   <= i_req.burst_estimate;
                        r_res_kind <= KIND_ACK;
                        r_res_id   <= '0;
                        r_idx      <= '0;
                        r_iss      <= 1'b1;
                        r_rd_v     <= 1'b0;
                        r_best_v   <= 1'b0;
                        case (i_req.operation)
                            OP_INSERT: begin
                                if (i_req.thread_priority >= r_bound_high) begin
                                    r_res_err <= ERR_PRI;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_res_err <= ERR_NONE;
                                    r_state   <= S_FREE;
                                end
                            end
                            OP_PICK: begin
                                r_res_err <= ERR_NONE;
                                r_lev     <= LEV_1;
                                r_state   <= S_SCAN;
                            end
                            OP_AGE: begin
                                r_res_err <= ERR_NONE;
                                r_lev     <= LEV_2;
                                r_done    <= '0;
                                r_state   <= S_SCAN;
                            end
                            default: begin
                                r_res_err <= ERR_NONE;
                                r_state   <= S_DONE;
                            end
                        endcase
                    end
                end

                // first free slot, one per cycle
                S_FREE: begin
                    if (!r_valid[r_idx]) begin
                        r_best_idx  <= r_idx;
                        r_best.id    <= r_tid;
                        r_best.pri   <= r_tpri;
                        r_best.burst <= r_tburst;
                        r_best.aging <= '0;
                        r_best.lev   <= (r_tpri < r_bound_low) ? LEV_3 :
                                        ((r_tpri < r_bound_mid) ? LEV_2 : LEV_1);
                        r_state      <= S_WRITE;
                    end else if (r_idx == LAST) begin
                        r_res_err <= ERR_FULL;
                        r_state   <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end

                // sweep: the compare sees each address in the cycle after it is issued
                S_SCAN: begin
                    r_rd_v   <= r_iss;
                    r_rd_idx <= r_idx;
                    if (r_iss) begin
                        if (r_idx == LAST) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (cand_take) begin
                        r_best_v   <= 1'b1;
                        r_best_idx <= r_rd_idx;
                        r_best     <= r_rdata;
                    end
                    if (scan_last) begin
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    // defaults for a follow-up sweep
                    r_idx    <= '0;
                    r_iss    <= 1'b1;
                    r_rd_v   <= 1'b0;
                    r_best_v <= 1'b0;
                    if (r_op == OP_AGE) begin
                        if (r_best_v) begin
                            r_state <= S_AGE;
                        end else if (r_lev == LEV_2) begin
                            r_lev   <= LEV_3;
                            r_done  <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (!r_best_v) begin
                        case (r_lev)
                            LEV_1: begin
                                r_lev   <= LEV_2;
                                r_state <= S_SCAN;
                            end
                            LEV_2: begin
                                r_lev   <= LEV_3;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_res_kind <= KIND_EMPTY;
                                r_state    <= S_DONE;
                            end
                        endcase
                    end else begin
                        r_state <= S_DONE;
                        if (!r_run
                            || ((r_lev == LEV_1) && ((r_cpri < r_bound_mid) || rem_gt))
                            || ((r_lev == LEV_3) && r_timer && (r_cpri < r_bound_low)))
                        begin
                            r_res_kind          <= KIND_NEW;
                            r_res_id            <= r_best.id;
                            r_valid[r_best_idx] <= 1'b0;
                        end else begin
                            r_res_kind <= KIND_KEEP;
                        end
                    end
                end

                S_AGE: begin
                    if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_best.aging <= ag_sum[AGE_W-1:0];
                        r_state      <= S_PROMO;
                    end
                end

                S_DIV: begin
                    if (div_done) begin
                        r_quot       <= div_quot;
                        r_best.aging <= div_rem;
                        r_state      <= S_MUL;
                    end
                end

                S_MUL: begin
                    r_prod  <= PROD_W'(r_age_step) * PROD_W'(r_quot);
                    r_state <= S_ADD;
                end

                S_ADD: begin
                    r_best.pri <= (pri_sum > (PROD_W + 1)'(8'hFF)) ? 8'hFF
                                  : pri_sum[PRI_W-1:0];
                    r_state    <= S_PROMO;
                end

                S_PROMO: begin
                    if ((r_lev == LEV_2) && (r_best.pri >= r_bound_mid)) begin
                        r_best.lev <= LEV_1;
                    end else if ((r_lev == LEV_3) && (r_best.pri >= r_bound_low)) begin
                        r_best.lev <= LEV_2;
                    end
                    r_state <= S_WRITE;
                end

                S_WRITE: begin
                    r_best.stamp        <= r_stamp;
                    r_stamp             <= r_stamp + 1'b1;
                    r_valid[r_best_idx] <= 1'b1;
                    r_done[r_best_idx]  <= 1'b1;
                    r_idx               <= '0;
                    r_iss               <= 1'b1;
                    r_rd_v              <= 1'b0;
                    r_best_v            <= 1'b0;
                    r_state             <= (r_op == OP_AGE) ? S_SCAN : S_DONE;
                end

                S_DONE: begin
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= r_res_kind;
                        r_o_err   <= r_res_err;
                        r_o_id    <= r_res_id;
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MFS_CHECK(a_one_at_a_time, i_clk, i_rst_n,
        i_req.valid && i_req.ready |=> !i_req.ready,
        "request taken while a previous one is in flight")
    `MFS_NEVER(a_err_only_on_ack, i_clk, i_rst_n,
        o_rsp.valid && (o_rsp.result_kind != KIND_ACK) && (o_rsp.error_code != ERR_NONE),
        "error code set on a pick response")
    `MFS_CHECK(a_stamp_step, i_clk, i_rst_n,
        i_rst_n |=> (r_stamp == $past(r_stamp)) || (r_stamp == $past(r_stamp) + 16'd1),
        "arrival stamp jumped")
    `MFS_CHECK(a_free_only_on_pick, i_clk, i_rst_n,
        i_rst_n && (r_op != OP_PICK) && (r_state != S_IDLE)
            |=> $countones(r_valid) >= $past($countones(r_valid)),
        "table slot freed outside a pick")

endmodule
